>>> rtl/u8sb_pkg.sv
`timescale 1ns / 1ps
package u8sb_pkg;

  localparam int unsigned MAX_ITEMS = 12;
  localparam int unsigned BUDGET_W  = 23;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 23'h400000;

  // replacement character, index 0 goes out first
  localparam logic [2:0][7:0] REPL = {8'hBD, 8'hBF, 8'hEF};

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] LEAD_SURR = 8'hED;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;
  localparam logic [7:0] E0_MIN   = 8'hA0;
  localparam logic [7:0] ED_MAX   = 8'h9F;
  localparam logic [7:0] F0_MIN   = 8'h90;
  localparam logic [7:0] F4_MAX   = 8'h8F;

  // one decoded step, handed from decoder to output shifter
  typedef struct packed {
    logic [MAX_ITEMS-1:0][7:0] bytes;
    logic [3:0]                n_items;
    logic                      data;
    logic                      last;
    logic                      trunc;
  } plan_t;

  // length of the sequence opened by a lead byte, 0 if it opens none
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
    else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
    else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
    return len;
  endfunction

  // narrowed range of the second byte after selected leads
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (lead == LEAD3_LO && b < E0_MIN) ok = 1'b0;
    if (lead == LEAD_SURR && b > ED_MAX) ok = 1'b0;
    if (lead == LEAD4_LO && b < F0_MIN) ok = 1'b0;
    if (lead == LEAD4_HI && b > F4_MAX) ok = 1'b0;
    return ok;
  endfunction

  // how many replacement units fit into a small room
  function automatic logic [2:0] fit3(input logic [3:0] r);
    logic [2:0] n;
    if (r >= 4'd15) n = 3'd5;
    else if (r >= 4'd12) n = 3'd4;
    else if (r >= 4'd9) n = 3'd3;
    else if (r >= 4'd6) n = 3'd2;
    else if (r >= 4'd3) n = 3'd1;
    else n = 3'd0;
    return n;
  endfunction

endpackage

>>> rtl/u8sb_if.sv
`timescale 1ns / 1ps
interface u8sb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface u8sb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       stream_done;
  logic       truncated;
  modport source (output valid, out_byte, byte_valid, run_last, stream_done, truncated,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, run_last, stream_done, truncated,
                output ready);
endinterface

interface u8sb_cfg_if;
  logic        valid;
  logic        ready;
  logic [22:0] out_budget;
  modport source (output valid, out_budget, input ready);
  modport sink (input valid, out_budget, output ready);
endinterface

>>> rtl/u8sb_decode.sv
`timescale 1ns / 1ps
module u8sb_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 cfg_we,
  input  logic [22:0]          cfg_budget,
  output u8sb_pkg::plan_t      plan
);

  logic [22:0]     budget;
  logic [22:0]     room;
  logic [22:0]     emitted;
  logic [7:0]      lead;
  logic [1:0][7:0] pend;
  logic [1:0]      pcount;
  logic [2:0]      exp_len;
  logic            stopped;

  logic       open_seq;
  logic       is_ascii;
  logic [2:0] new_len;
  logic       cont_ok;
  logic       complete;
  logic       extend;
  logic       restart;
  logic [2:0] r_cnt;
  logic [2:0] dlen;
  logic [3:0][7:0] dbytes;
  logic [3:0] room_small;
  logic [2:0] fit;
  logic [2:0] nr;
  logic       rep_ok;
  logic [4:0] need;
  logic       data_ok;
  logic       stop_now;
  logic [3:0] rep_bytes;
  logic [3:0] nbytes;

  // classify the byte against the open sequence
  always_comb begin
    open_seq = (exp_len != 3'd0);
    is_ascii = (in_byte >= 8'h01) && (in_byte <= 8'h7F);
    new_len  = u8sb_pkg::seq_len(in_byte);
    cont_ok  = (in_byte >= u8sb_pkg::CONT_LO) && (in_byte <= u8sb_pkg::CONT_HI) &&
               ((pcount != 2'd0) || u8sb_pkg::second_ok(lead, in_byte));
    complete = open_seq && cont_ok && (({1'b0, pcount} + 3'd2) >= exp_len);
    extend   = open_seq && cont_ok && !complete;
    restart  = !open_seq || !cont_ok;
  end

  // build the unit list: replacement units first, then at most one data unit
  always_comb begin
    r_cnt  = 3'd0;
    dlen   = 3'd0;
    dbytes = '0;
    if (restart) begin
      if (open_seq) r_cnt = 3'd1 + {1'b0, pcount};
      if (is_ascii) begin
        dlen      = 3'd1;
        dbytes[0] = in_byte;
      end else if (new_len != 3'd0) begin
        r_cnt = r_cnt + {2'b00, in_last};
      end else begin
        r_cnt = r_cnt + 3'd1;
      end
    end else if (complete) begin
      dlen      = {1'b0, pcount} + 3'd2;
      dbytes[0] = lead;
      dbytes[1] = (pcount != 2'd0) ? pend[0] : in_byte;
      dbytes[2] = (pcount == 2'd2) ? pend[1] : in_byte;
      dbytes[3] = in_byte;
    end else if (extend && in_last) begin
      r_cnt = 3'd2 + {1'b0, pcount};
    end
  end

  // budget check against the room left, saturated to four bits
  always_comb begin
    room_small = (|room[22:4]) ? 4'hF : room[3:0];
    fit        = u8sb_pkg::fit3(room_small);
    nr         = (r_cnt < fit) ? r_cnt : fit;
    rep_ok     = (nr == r_cnt);
    need       = {1'b0, r_cnt, 1'b0} + {2'b00, r_cnt} + {2'b00, dlen};
    data_ok    = rep_ok && (dlen != 3'd0) && (need <= {1'b0, room_small});
    stop_now   = !rep_ok || ((dlen != 3'd0) && !data_ok);
    rep_bytes  = {nr, 1'b0} + {1'b0, nr};
    nbytes     = rep_bytes + (data_ok ? {1'b0, dlen} : 4'd0);
  end

  // lay out the words of this step
  always_comb begin
    logic [1:0] ph;
    logic [3:0] j;
    ph   = 2'd0;
    j    = 4'd0;
    plan = '0;
    for (int i = 0; i < u8sb_pkg::MAX_ITEMS; i++) begin
      j = 4'(i) - rep_bytes;
      if (4'(i) < rep_bytes) begin
        plan.bytes[i] = u8sb_pkg::REPL[ph];
      end else if (data_ok && (j < {1'b0, dlen})) begin
        plan.bytes[i] = dbytes[j[1:0]];
      end
      ph = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
    end
    plan.last = in_last;
    if (stopped) begin
      plan.bytes   = '0;
      plan.n_items = in_last ? 4'd1 : 4'd0;
      plan.data    = 1'b0;
      plan.trunc   = 1'b1;
    end else begin
      plan.data    = (nbytes != 4'd0);
      plan.n_items = (nbytes != 4'd0) ? nbytes :
                     ((in_last || stop_now) ? 4'd1 : 4'd0);
      plan.trunc   = stop_now;
    end
  end

  // advance the stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      budget  <= u8sb_pkg::BUDGET_RESET;
      room    <= u8sb_pkg::BUDGET_RESET;
      emitted <= '0;
      lead    <= '0;
      pcount  <= '0;
      exp_len <= '0;
      stopped <= 1'b0;
    end else if (cfg_we) begin
      budget <= cfg_budget;
      room   <= (cfg_budget > emitted) ? cfg_budget - emitted : '0;
    end else if (advance) begin
      if (in_last) begin
        room    <= budget;
        emitted <= '0;
        lead    <= '0;
        pcount  <= '0;
        exp_len <= '0;
        stopped <= 1'b0;
      end else if (!stopped) begin
        stopped <= stop_now;
        emitted <= emitted + {19'd0, nbytes};
        room    <= room - {19'd0, nbytes};
        if (restart) begin
          lead    <= in_byte;
          pcount  <= 2'd0;
          exp_len <= new_len;
        end else if (complete) begin
          pcount  <= 2'd0;
          exp_len <= 3'd0;
        end else begin
          pend[pcount[0]] <= in_byte;
          pcount          <= pcount + 2'd1;
        end
      end
    end
  end

endmodule

>>> rtl/u8sb_emit.sv
`timescale 1ns / 1ps
module u8sb_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  u8sb_pkg::plan_t  plan,
  output logic             can_load,
  u8sb_out_if.source       res
);

  logic [u8sb_pkg::MAX_ITEMS-1:0][7:0] bytes;
  logic [3:0] count;
  logic       data;
  logic       last;
  logic       trunc;
  logic       take;

  assign take     = res.valid && res.ready;
  assign can_load = (count == 4'd0) || (take && (count == 4'd1));

  // hold the current step and shift one word out per take
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= plan.n_items;
    end else if (take) begin
      count <= count - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= plan.bytes;
      data  <= plan.data;
      last  <= plan.last;
      trunc <= plan.trunc;
    end else if (take) begin
      bytes <= {8'h00, bytes[u8sb_pkg::MAX_ITEMS-1:1]};
    end
  end

  assign res.valid       = (count != 4'd0);
  assign res.out_byte    = bytes[0];
  assign res.byte_valid  = data;
  assign res.run_last    = (count == 4'd1);
  assign res.stream_done = last && (count == 4'd1);
  assign res.truncated   = trunc;

endmodule

>>> rtl/utf8_sanitizer_with_budget.sv
`timescale 1ns / 1ps
// UTF-8 sanitizer with an output byte budget. Bytes enter one per word with an
// end-of-stream mark; well-formed UTF-8 other than 00 passes unchanged, anything
// else becomes EF BF BD, and output stops with the truncated flag once a unit
// would exceed out_budget. Valid text flows at one byte per cycle while the
// output is ready. A byte that expands into N output words (up to 12, for a
// four-byte sequence cut by a bad byte) holds the input until the output
// shifter has sent them, one word per take; a dropped byte sends no word.
// out_budget must be written only while the block is idle; it is not enforced.
module utf8_sanitizer_with_budget (
  input  logic        clk,
  input  logic        rst,
  u8sb_in_if.sink     byte_in,
  u8sb_out_if.source  result_out,
  u8sb_cfg_if.sink    cfg
);

  logic            inq_valid;
  logic [7:0]      inq_byte;
  logic            inq_last;
  logic            can_load;
  logic            load;
  u8sb_pkg::plan_t plan;

  assign load          = inq_valid && can_load;
  assign byte_in.ready = !inq_valid || load;
  assign cfg.ready     = 1'b1;

  // hold one accepted word until the decoder takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      inq_valid <= 1'b1;
    end else if (load) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      inq_byte <= byte_in.in_byte;
      inq_last <= byte_in.in_last;
    end
  end

  u8sb_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .advance    (load),
    .in_byte    (inq_byte),
    .in_last    (inq_last),
    .cfg_we     (cfg.valid && cfg.ready),
    .cfg_budget (cfg.out_budget),
    .plan       (plan)
  );

  u8sb_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .plan     (plan),
    .can_load (can_load),
    .res      (result_out)
  );

  // a status word stands alone in its run
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.byte_valid) |-> result_out.run_last)
    else $error("status word not last of its run");

  // a status word only reports stream end or a budget stop
  a_status_reason: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.byte_valid) |->
      (result_out.stream_done || result_out.truncated))
    else $error("status word without cause");

  // a run has no gaps once it has started
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.ready && !result_out.run_last) |=> result_out.valid)
    else $error("gap inside a run");

  // the input register never takes a new word while one is stranded
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (inq_valid && !can_load) |-> !byte_in.ready)
    else $error("input word overwritten");

endmodule

>>> dv/tb_utf8_sanitizer_with_budget.sv
`timescale 1ns / 1ps
module tb_utf8_sanitizer_with_budget;

  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 24;

  typedef enum logic {ROW_BYTE, ROW_BUDGET} row_kind_t;

  // one line of the directed table: a byte or a budget write
  typedef struct packed {
    row_kind_t   kind;
    logic [22:0] value;
    logic        last;
    logic        chk;
    logic [3:0]  n;
    logic [7:0]  first;
    logic        trunc;
  } row_t;

  // one output word
  typedef struct packed {
    logic [7:0] ob;
    logic       bv;
    logic       rl;
    logic       sd;
    logic       tr;
  } word_t;

  logic clk = 1'b0;
  logic rst;

  u8sb_in_if  byte_in ();
  u8sb_out_if result_out ();
  u8sb_cfg_if cfg ();

  utf8_sanitizer_with_budget dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sanitizer state as predicted
  logic [22:0]     budget_q;
  logic [22:0]     emitted_q;
  logic [7:0]      lead_q;
  logic [1:0][7:0] pend_q;
  logic [1:0]      npend_q;
  logic [2:0]      seq_len_q;
  logic            stopped_q;
  logic [7:0]      step_bytes[$];

  word_t expected_words[$];
  int    fails = 0;
  int    live_items = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  // directed-row tags travel with the word they belong to
  logic       tag_chk;
  logic [3:0] tag_n;
  logic [7:0] tag_first;
  logic       tag_trunc;

  function automatic void clear_stream();
    lead_q    = 8'h00;
    pend_q    = '0;
    npend_q   = 2'd0;
    seq_len_q = 3'd0;
    emitted_q = 23'd0;
    stopped_q = 1'b0;
  endfunction

  // write a unit only if it fits in the room left, else stop the stream
  function automatic void put_unit(input logic [3:0][7:0] u, input int len);
    int room;
    if (stopped_q) return;
    room = (budget_q > emitted_q) ? int'(budget_q - emitted_q) : 0;
    if (len > room) begin
      stopped_q = 1'b1;
      return;
    end
    for (int i = 0; i < len; i++) step_bytes = {step_bytes, u[i]};
    emitted_q = emitted_q + 23'(len);
  endfunction

  function automatic void put_repl();
    put_unit({8'h00, u8sb_pkg::REPL}, 3);
  endfunction

  function automatic void open_lead(input logic [7:0] b);
    npend_q   = 2'd0;
    seq_len_q = 3'd0;
    lead_q    = b;
    if (b >= 8'h01 && b <= 8'h7F) put_unit({24'h0, b}, 1);
    else if (b >= u8sb_pkg::LEAD2_LO && b <= u8sb_pkg::LEAD2_HI) seq_len_q = 3'd2;
    else if (b >= u8sb_pkg::LEAD3_LO && b <= u8sb_pkg::LEAD3_HI) seq_len_q = 3'd3;
    else if (b >= u8sb_pkg::LEAD4_LO && b <= u8sb_pkg::LEAD4_HI) seq_len_q = 3'd4;
    else put_repl();
  endfunction

  // replace the lead and every buffered byte of an open sequence
  function automatic void close_open_seq();
    if (seq_len_q == 3'd0) return;
    put_repl();
    for (int i = 0; i < int'(npend_q); i++) put_repl();
    seq_len_q = 3'd0;
    npend_q   = 2'd0;
  endfunction

  function automatic logic second_fits(input logic [7:0] lead, input logic [7:0] b);
    if (lead == u8sb_pkg::LEAD3_LO && b < u8sb_pkg::E0_MIN) return 1'b0;
    if (lead == u8sb_pkg::LEAD_SURR && b > u8sb_pkg::ED_MAX) return 1'b0;
    if (lead == u8sb_pkg::LEAD4_LO && b < u8sb_pkg::F0_MIN) return 1'b0;
    if (lead == u8sb_pkg::LEAD4_HI && b > u8sb_pkg::F4_MAX) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    logic            ok;
    logic [3:0][7:0] u;
    int              k;
    if (seq_len_q == 3'd0) begin
      open_lead(b);
      return;
    end
    ok = (b >= u8sb_pkg::CONT_LO && b <= u8sb_pkg::CONT_HI);
    if (ok && npend_q == 2'd0) ok = second_fits(lead_q, b);
    if (!ok) begin
      close_open_seq();
      open_lead(b);
      return;
    end
    k = int'(npend_q);
    if (k + 2 >= int'(seq_len_q)) begin
      u    = '0;
      u[0] = lead_q;
      for (int i = 0; i < k; i++) u[i+1] = pend_q[i];
      u[k+1]    = b;
      seq_len_q = 3'd0;
      npend_q   = 2'd0;
      put_unit(u, k + 2);
    end else begin
      pend_q[npend_q[0]] = b;
      npend_q = npend_q + 2'd1;
    end
  endfunction

  // sanitize one input byte and queue the words it causes
  function automatic int sanitize_step(input logic [7:0] b, input logic last);
    logic  was_stopped;
    int    nd;
    int    n;
    word_t w;
    was_stopped = stopped_q;
    step_bytes.delete();
    if (!was_stopped) begin
      take_byte(b);
      if (last) close_open_seq();
    end
    nd = step_bytes.size();
    n  = nd;
    if (n == 0 && (last || (stopped_q && !was_stopped))) n = 1;
    for (int k = 0; k < n; k++) begin
      w.ob = (k < nd) ? step_bytes[k] : 8'h00;
      w.bv = (k < nd);
      w.rl = (k == n - 1);
      w.sd = last && (k == n - 1);
      w.tr = stopped_q;
      expected_words = {expected_words, w};
    end
    if (last) clear_stream();
    return n;
  endfunction

  task automatic note_fail(input string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endtask

  // receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    result_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // track accepted words, predict, and check the output
  always @(posedge clk) begin : watch_words
    int    n;
    word_t e;
    word_t got;
    if (!rst) begin
      if (cfg.valid && cfg.ready) budget_q = cfg.out_budget;
      if (byte_in.valid && byte_in.ready) begin
        live_items++;
        n = sanitize_step(byte_in.in_byte, byte_in.in_last);
        if (tag_chk) begin
          if (n != int'(tag_n))
            note_fail($sformatf("byte %02h: expected %0d words, predicted %0d",
                                byte_in.in_byte, tag_n, n));
          else if (n > 0) begin
            e = expected_words[expected_words.size() - n];
            if (e.ob !== tag_first || e.tr !== tag_trunc)
              note_fail($sformatf("byte %02h: expected first %02h trunc %0b, predicted %02h %0b",
                                  byte_in.in_byte, tag_first, tag_trunc, e.ob, e.tr));
          end
        end
      end
      if (result_out.valid && result_out.ready) begin
        got = '{result_out.out_byte, result_out.byte_valid, result_out.run_last,
                result_out.stream_done, result_out.truncated};
        if (expected_words.size() == 0) begin
          note_fail($sformatf("unexpected word: byte %02h valid %0b last %0b done %0b trunc %0b",
                              got.ob, got.bv, got.rl, got.sd, got.tr));
        end else begin
          e = expected_words[0];
          expected_words.delete(0);
          if (got !== e)
            note_fail($sformatf({"word mismatch: expected byte %02h valid %0b last %0b ",
                                 "done %0b trunc %0b, got byte %02h valid %0b last %0b ",
                                 "done %0b trunc %0b"},
                                e.ob, e.bv, e.rl, e.sd, e.tr,
                                got.ob, got.bv, got.rl, got.sd, got.tr));
        end
      end
    end
  end

  // drive one word, idling first at the rate of the current phase
  task automatic send_word(input logic [7:0] b, input logic last, input logic chk,
                           input logic [3:0] n, input logic [7:0] first,
                           input logic trunc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    byte_in.valid   <= 1'b1;
    byte_in.in_byte <= b;
    byte_in.in_last <= last;
    tag_chk   <= chk;
    tag_n     <= n;
    tag_first <= first;
    tag_trunc <= trunc;
    do @(posedge clk); while (!byte_in.ready);
  endtask

  // hold input, drain the block, then write the budget
  task automatic write_budget(input logic [22:0] v);
    byte_in.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg.valid      <= 1'b1;
    cfg.out_budget <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [22:0] pick_budget();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return u8sb_pkg::BUDGET_RESET;
    if (r < 70) return 23'($urandom_range(1, 30));
    if (r < 80) return 23'd1;
    if (r < 90) return 23'($urandom_range(31, 2000));
    return 23'($urandom_range(1, 4194304));
  endfunction

  function automatic logic [7:0] any_cont();
    return 8'($urandom_range(u8sb_pkg::CONT_LO, u8sb_pkg::CONT_HI));
  endfunction

  // second byte that respects the narrowed range of its lead
  function automatic logic [7:0] second_byte(input logic [7:0] lead);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = (lead == u8sb_pkg::LEAD3_LO) ? u8sb_pkg::E0_MIN :
         (lead == u8sb_pkg::LEAD4_LO) ? u8sb_pkg::F0_MIN : u8sb_pkg::CONT_LO;
    hi = (lead == u8sb_pkg::LEAD_SURR) ? u8sb_pkg::ED_MAX :
         (lead == u8sb_pkg::LEAD4_HI) ? u8sb_pkg::F4_MAX : u8sb_pkg::CONT_HI;
    return 8'($urandom_range(lo, hi));
  endfunction

  // mostly well-formed units, some broken sequences and raw noise
  task automatic send_unit(input logic ends_stream);
    logic [7:0] seq[$];
    logic [7:0] lead;
    int         pick;
    int         need;
    int         good;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      seq = {seq, 8'($urandom_range(1, 127))};
    end else if (pick < 50) begin
      lead = 8'($urandom_range(u8sb_pkg::LEAD2_LO, u8sb_pkg::LEAD2_HI));
      seq  = '{lead, any_cont()};
    end else if (pick < 68) begin
      lead = 8'($urandom_range(u8sb_pkg::LEAD3_LO, u8sb_pkg::LEAD3_HI));
      seq  = '{lead, second_byte(lead), any_cont()};
    end else if (pick < 82) begin
      lead = 8'($urandom_range(u8sb_pkg::LEAD4_LO, u8sb_pkg::LEAD4_HI));
      seq  = '{lead, second_byte(lead), any_cont(), any_cont()};
    end else if (pick < 90) begin
      lead = 8'($urandom_range(u8sb_pkg::LEAD2_LO, u8sb_pkg::LEAD4_HI));
      need = (lead < u8sb_pkg::LEAD3_LO) ? 2 : (lead < u8sb_pkg::LEAD4_LO) ? 3 : 4;
      good = $urandom_range(0, need - 2);
      seq  = {seq, lead};
      for (int i = 0; i < good; i++) seq = {seq, (i == 0) ? second_byte(lead) : any_cont()};
      if ($urandom_range(0, 9) < 7) seq = {seq, 8'($urandom_range(0, 255))};
    end else begin
      repeat ($urandom_range(1, 3)) seq = {seq, 8'($urandom_range(0, 255))};
    end
    foreach (seq[i])
      send_word(seq[i], ends_stream && (i == seq.size() - 1), 1'b0, 4'd0, 8'h00, 1'b0);
  endtask

  task automatic send_stream();
    int units;
    units = $urandom_range(1, 30);
    for (int u = 0; u < units; u++) begin
      if ($urandom_range(0, 99) < 3) write_budget(pick_budget());
      send_unit(u == units - 1);
    end
  endtask

  initial begin : stimulus
    row_t dir_rows[$];
    int   base;
    int   streams;
    rst              = 1'b1;
    byte_in.valid    = 1'b0;
    byte_in.in_byte  = 8'h00;
    byte_in.in_last  = 1'b0;
    result_out.ready = 1'b0;
    cfg.valid        = 1'b0;
    cfg.out_budget   = u8sb_pkg::BUDGET_RESET;
    tag_chk          = 1'b0;
    tag_n            = 4'd0;
    tag_first        = 8'h00;
    tag_trunc        = 1'b0;
    budget_q         = u8sb_pkg::BUDGET_RESET;
    clear_stream();

    dir_rows = '{
      // budget from reset: ASCII extremes, 00, and C2 and E0 sequences
      '{ROW_BYTE, 23'h41, 1'b0, 1'b1, 4'd1, 8'h41, 1'b0},
      '{ROW_BYTE, 23'h00, 1'b0, 1'b1, 4'd3, 8'hEF, 1'b0},
      '{ROW_BYTE, 23'h7F, 1'b0, 1'b1, 4'd1, 8'h7F, 1'b0},
      '{ROW_BYTE, 23'hC2, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h80, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'hE0, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'hA0, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'hBF, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      // surrogate range cut at the second byte, then the highest four-byte sequence
      '{ROW_BYTE, 23'hED, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'hA0, 1'b0, 1'b1, 4'd6, 8'hEF, 1'b0},
      '{ROW_BYTE, 23'hF4, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h8F, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h80, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'hBF, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      // four-byte sequence broken by a bad byte: longest expansion
      '{ROW_BYTE, 23'hF0, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h90, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h80, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'hFF, 1'b0, 1'b1, 4'd12, 8'hEF, 1'b0},
      // sequence cut by the end of the stream
      '{ROW_BYTE, 23'hE1, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h80, 1'b1, 1'b1, 4'd6, 8'hEF, 1'b0},
      // budget of one: stop without data, dropped byte, status at end
      '{ROW_BUDGET, 23'd1, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'hC2, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h80, 1'b0, 1'b1, 4'd1, 8'h00, 1'b1},
      '{ROW_BYTE, 23'h41, 1'b0, 1'b1, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h41, 1'b1, 1'b1, 4'd1, 8'h00, 1'b1},
      // lower the budget below what the open stream already wrote
      '{ROW_BUDGET, 23'd4, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h41, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h41, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h41, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BUDGET, 23'd2, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0},
      '{ROW_BYTE, 23'h41, 1'b0, 1'b1, 4'd1, 8'h00, 1'b1},
      '{ROW_BYTE, 23'h01, 1'b1, 1'b1, 4'd1, 8'h00, 1'b1},
      '{ROW_BUDGET, 23'h400000, 1'b0, 1'b0, 4'd0, 8'h00, 1'b0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_BUDGET)
        write_budget(dir_rows[i].value);
      else
        send_word(dir_rows[i].value[7:0], dir_rows[i].last, dir_rows[i].chk,
                  dir_rows[i].n, dir_rows[i].first, dir_rows[i].trunc);
    end

    // random streams, stepping through the idle and stall phases by items sent
    base    = live_items;
    streams = 0;
    while (live_items - base < RANDOM_ITEMS) begin
      case (((live_items - base) * 4) / RANDOM_ITEMS)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 51;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
      endcase
      if ($urandom_range(0, 99) < 40) write_budget(pick_budget());
      send_stream();
      streams++;
    end

    // drain and report
    byte_in.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && expected_words.size() == 0) begin
      $display("tb_utf8_sanitizer_with_budget OK");
    end else begin
      $display("tb_utf8_sanitizer_with_budget NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("tb_utf8_sanitizer_with_budget NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/u8sb_pkg.sv
rtl/u8sb_if.sv
rtl/u8sb_decode.sv
rtl/u8sb_emit.sv
rtl/utf8_sanitizer_with_budget.sv
dv/tb_utf8_sanitizer_with_budget.sv
